[rtl/clock_with_digit_scan_and_key_set_core_macros.svh]
// Assertion macros used by the clock core RTL.
`ifndef CLOCK_WITH_DIGIT_SCAN_AND_KEY_SET_CORE_MACROS_SVH
`define CLOCK_WITH_DIGIT_SCAN_AND_KEY_SET_CORE_MACROS_SVH

// Same-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define CWDS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define CWDS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[rtl/cwds_pkg.sv]
// Types, codes and helper functions for the twelve-hour clock core.
package cwds_pkg;

    localparam int DIGIT_COUNT = 6;

    // Event kinds.
    localparam logic [1:0] FUNC_SEC  = 2'd0;
    localparam logic [1:0] FUNC_SCAN = 2'd1;
    localparam logic [1:0] FUNC_KEY  = 2'd2;

    // Key codes.
    localparam logic [7:0] KEY_ZERO  = 8'd48;
    localparam logic [7:0] KEY_NINE  = 8'd57;
    localparam logic [7:0] KEY_ONE   = 8'd49;
    localparam logic [7:0] KEY_EQUAL = 8'd61;

    // Entry positions, next expected digit.
    localparam logic [2:0] POS_HOUR_TENS  = 3'd5;
    localparam logic [2:0] POS_HOUR_UNITS = 3'd4;
    localparam logic [2:0] POS_MIN_TENS   = 3'd3;
    localparam logic [2:0] POS_MIN_UNITS  = 3'd2;
    localparam logic [2:0] POS_SEC_TENS   = 3'd1;
    localparam logic [2:0] POS_SEC_UNITS  = 3'd0;

    // Count limits and reset values.
    localparam logic [5:0] MS_MAX      = 6'd59;
    localparam logic [3:0] HOUR_MAX    = 4'd12;
    localparam logic [3:0] HOUR_FIRST  = 4'd1;
    localparam logic [5:0] SEC_RESET   = 6'd55;
    localparam logic [3:0] HOUR_RESET  = 4'd12;
    localparam logic [3:0] HOUR_TEN    = 4'd10;

    typedef logic [1:0] t_func;

    typedef struct packed {
        logic [DIGIT_COUNT-1:0] enable_n;
        logic [3:0]             value;
        logic                   blank;
    } t_disp;

    // Tens digit of a six-bit value, by a short compare chain.
    function automatic logic [2:0] f_tens(input logic [5:0] v);
        logic [2:0] t;
        if      (v >= 6'd60) t = 3'd6;
        else if (v >= 6'd50) t = 3'd5;
        else if (v >= 6'd40) t = 3'd4;
        else if (v >= 6'd30) t = 3'd3;
        else if (v >= 6'd20) t = 3'd2;
        else if (v >= 6'd10) t = 3'd1;
        else                 t = 3'd0;
        return t;
    endfunction

    // Small value times ten, as shifts and an add.
    function automatic logic [5:0] f_times_ten(input logic [2:0] d);
        return {d, 3'b000} + {2'b00, d, 1'b0};
    endfunction

endpackage

[rtl/cwds_if.sv]
// Event and result channel interfaces of the clock core.
interface cwds_evt_if;
    import cwds_pkg::*;
    logic       valid;
    logic       ready;
    t_func      func;
    logic [7:0] key_code;

    modport source (output valid, output func, output key_code, input ready);
    modport sink   (input valid, input func, input key_code, output ready);
endinterface

interface cwds_res_if;
    import cwds_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [DIGIT_COUNT-1:0] digit_enable_n;
    logic [3:0]             digit_value;
    logic                   digit_blank;
    logic [5:0]             seconds_now;
    logic [5:0]             minutes_now;
    logic [3:0]             hours_now;
    logic                   entry_active;
    logic [2:0]             entry_position;

    modport source (
        output valid, output digit_enable_n, output digit_value, output digit_blank,
        output seconds_now, output minutes_now, output hours_now,
        output entry_active, output entry_position, input ready
    );
    modport sink (
        input valid, input digit_enable_n, input digit_value, input digit_blank,
        input seconds_now, input minutes_now, input hours_now,
        input entry_active, input entry_position, output ready
    );
endinterface

[rtl/cwds_disp.sv]
// Display digit selection: picks the scanned digit, splits it to BCD and blanks it when out of range.
module cwds_disp (
    input  logic [5:0]     i_sec,
    input  logic [5:0]     i_min,
    input  logic [3:0]     i_hour,
    input  logic [2:0]     i_scan,
    output cwds_pkg::t_disp o_disp
);
    import cwds_pkg::*;

    logic [2:0] idx;
    logic [5:0] field;
    logic       over;
    logic [2:0] tens;
    logic [5:0] units;

    always_comb begin
        idx = (i_scan >= 3'(DIGIT_COUNT)) ? i_scan - 3'(DIGIT_COUNT) : i_scan;
        case (idx)
            3'd0, 3'd1: begin
                field = i_sec;
                over  = i_sec > MS_MAX;
            end
            3'd2, 3'd3: begin
                field = i_min;
                over  = i_min > MS_MAX;
            end
            default: begin
                field = {2'b00, i_hour};
                over  = i_hour > HOUR_MAX;
            end
        endcase
        tens  = f_tens(field);
        units = field - f_times_ten(tens);

        o_disp.enable_n = ~(DIGIT_COUNT'(1) << idx);
        o_disp.blank    = over;
        if (over) begin
            o_disp.value = 4'd0;
        end else if (idx[0]) begin
            o_disp.value = {1'b0, tens};
        end else begin
            o_disp.value = units[3:0];
        end
    end

endmodule

[rtl/clock_with_digit_scan_and_key_set_core.sv]
// Twelve-hour clock core with display digit scan and keypad time setting.
//
//   channel | direction | beat contents
//   --------+-----------+------------------------------------------------------
//   i_evt   | in        | func (second tick, scan tick, key press), key_code
//   o_res   | out       | digit select, BCD digit, blank, time, entry status
//
// Every event beat produces exactly one result beat, in the cycle after it is taken.
// The clock state and the result are both updated by one short combinational pass
// from the event and the current state, so a new event can be taken every cycle while o_res drains.
// i_evt.ready is high whenever the result register is empty or is being drained in
// the same cycle; a stalled o_res holds its beat and blocks only further events.
// Reset is synchronous on i_rst_n: the time returns to 12:00:55, the scan to the
// seconds units digit, entry is left and the result register is emptied.
`include "clock_with_digit_scan_and_key_set_core_macros.svh"

module clock_with_digit_scan_and_key_set_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cwds_evt_if.sink  i_evt,
    cwds_res_if.source o_res
);
    import cwds_pkg::*;

    // Clock and entry state.
    logic [5:0] r_sec,      n_sec;
    logic [5:0] r_min,      n_min;
    logic [3:0] r_hour,     n_hour;
    logic [2:0] r_scan,     n_scan;
    logic       r_entering, n_entering;
    logic [2:0] r_position, n_position;
    logic [3:0] r_ent_hour, n_ent_hour;
    logic [5:0] r_ent_min,  n_ent_min;
    logic [5:0] r_ent_sec,  n_ent_sec;

    // Result register.
    logic       r_out_valid;
    t_disp      r_disp;
    logic [5:0] r_out_sec;
    logic [5:0] r_out_min;
    logic [3:0] r_out_hour;
    logic       r_out_entering;
    logic [2:0] r_out_position;

    logic       w_ready;
    logic       w_in_fire;
    logic       w_out_fire;
    t_disp      w_disp;

    // Working values of the tick and key logic.
    logic [6:0] sec_inc;
    logic [6:0] min_inc;
    logic [4:0] hour_inc;
    logic [7:0] key_off;
    logic [3:0] digit;
    logic       is_digit;
    logic [3:0] digit_top;
    logic       pos_ok;

    assign w_ready    = !r_out_valid || o_res.ready;
    assign w_in_fire  = i_evt.valid && w_ready;
    assign w_out_fire = r_out_valid && o_res.ready;
    assign i_evt.ready = w_ready;

    always_comb begin
        n_sec      = r_sec;
        n_min      = r_min;
        n_hour     = r_hour;
        n_scan     = r_scan;
        n_entering = r_entering;
        n_position = r_position;
        n_ent_hour = r_ent_hour;
        n_ent_min  = r_ent_min;
        n_ent_sec  = r_ent_sec;

        sec_inc  = {1'b0, r_sec} + 7'd1;
        min_inc  = {1'b0, r_min} + 7'd1;
        hour_inc = {1'b0, r_hour} + 5'd1;

        key_off  = i_evt.key_code - KEY_ZERO;
        digit    = key_off[3:0];
        is_digit = (i_evt.key_code >= KEY_ZERO) && (i_evt.key_code <= KEY_NINE);

        // Highest digit allowed at the current entry position.
        pos_ok = 1'b1;
        case (r_position)
            POS_HOUR_TENS:  digit_top = 4'd1;
            POS_HOUR_UNITS: digit_top = (r_ent_hour >= HOUR_TEN) ? 4'd2 : 4'd9;
            POS_MIN_TENS:   digit_top = 4'd5;
            POS_MIN_UNITS:  digit_top = 4'd9;
            POS_SEC_TENS:   digit_top = 4'd5;
            POS_SEC_UNITS:  digit_top = 4'd9;
            default: begin
                digit_top = 4'd0;
                pos_ok    = 1'b0;
            end
        endcase

        if (w_in_fire) begin
            case (i_evt.func)
                FUNC_SEC: begin
                    // Seconds, then minutes, then hours carry; hour wraps 12 to 1.
                    if (sec_inc > {1'b0, MS_MAX}) begin
                        n_sec = 6'd0;
                        if (min_inc > {1'b0, MS_MAX}) begin
                            n_min  = 6'd0;
                            n_hour = (hour_inc > {1'b0, HOUR_MAX}) ? HOUR_FIRST
                                                                   : hour_inc[3:0];
                        end else begin
                            n_min = min_inc[5:0];
                        end
                    end else begin
                        n_sec = sec_inc[5:0];
                    end
                end
                FUNC_SCAN: begin
                    n_scan = (r_scan >= 3'(DIGIT_COUNT - 1)) ? 3'd0 : r_scan + 3'd1;
                end
                FUNC_KEY: begin
                    if (!r_entering) begin
                        if (i_evt.key_code == KEY_ONE) begin
                            n_entering = 1'b1;
                            n_position = POS_HOUR_TENS;
                        end
                    end else if (i_evt.key_code == KEY_EQUAL) begin
                        n_entering = 1'b0;
                        n_position = POS_HOUR_TENS;
                    end else if (is_digit && pos_ok && (digit <= digit_top)) begin
                        n_position = r_position - 3'd1;
                        case (r_position)
                            POS_HOUR_TENS:  n_ent_hour = digit[0] ? HOUR_TEN : 4'd0;
                            POS_HOUR_UNITS: n_ent_hour = r_ent_hour + digit;
                            POS_MIN_TENS:   n_ent_min  = f_times_ten(digit[2:0]);
                            POS_MIN_UNITS:  n_ent_min  = r_ent_min + {2'b00, digit};
                            POS_SEC_TENS:   n_ent_sec  = f_times_ten(digit[2:0]);
                            default: begin
                                // Last digit: load the entered time and leave entry.
                                n_ent_sec  = r_ent_sec + {2'b00, digit};
                                n_sec      = n_ent_sec;
                                n_min      = r_ent_min;
                                n_hour     = r_ent_hour;
                                n_entering = 1'b0;
                                n_position = POS_HOUR_TENS;
                            end
                        endcase
                    end
                end
                default: begin
                    // The unused event kind leaves the state alone.
                end
            endcase
        end
    end

    // The result shows the display as it stands after the event.
    cwds_disp u_disp (
        .i_sec  (n_sec),
        .i_min  (n_min),
        .i_hour (n_hour),
        .i_scan (n_scan),
        .o_disp (w_disp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec       <= SEC_RESET;
            r_min       <= 6'd0;
            r_hour      <= HOUR_RESET;
            r_scan      <= 3'd0;
            r_entering  <= 1'b0;
            r_position  <= POS_HOUR_TENS;
            r_ent_hour  <= 4'd0;
            r_ent_min   <= 6'd0;
            r_ent_sec   <= 6'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_sec      <= n_sec;
            r_min      <= n_min;
            r_hour     <= n_hour;
            r_scan     <= n_scan;
            r_entering <= n_entering;
            r_position <= n_position;
            r_ent_hour <= n_ent_hour;
            r_ent_min  <= n_ent_min;
            r_ent_sec  <= n_ent_sec;
            if (w_in_fire) begin
                r_out_valid <= 1'b1;
            end else if (w_out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload loads with each taken event and holds while stalled.
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_disp         <= w_disp;
            r_out_sec      <= n_sec;
            r_out_min      <= n_min;
            r_out_hour     <= n_hour;
            r_out_entering <= n_entering;
            r_out_position <= n_position;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.digit_enable_n = r_disp.enable_n;
    assign o_res.digit_value    = r_disp.value;
    assign o_res.digit_blank    = r_disp.blank;
    assign o_res.seconds_now    = r_out_sec;
    assign o_res.minutes_now    = r_out_min;
    assign o_res.hours_now      = r_out_hour;
    assign o_res.entry_active   = r_out_entering;
    assign o_res.entry_position = r_out_position;

    `CWDS_ASSERT_NOW(a_pos_parked, !r_entering, r_position == POS_HOUR_TENS, "position moved outside entry")
    `CWDS_ASSERT_NOW(a_scan_range, 1'b1, r_scan < 3'(DIGIT_COUNT), "scan index out of range")
    `CWDS_ASSERT_NOW(a_time_range, 1'b1, (r_sec <= MS_MAX) && (r_min <= MS_MAX) && (r_hour <= HOUR_MAX), "clock count out of range")
    `CWDS_ASSERT_NEXT(a_result_follows, w_in_fire, r_out_valid, "taken event left no result")
    `CWDS_ASSERT_NOW(a_ready_when_empty, !r_out_valid, i_evt.ready, "event refused while result register empty")

endmodule

[sim/clock_with_digit_scan_and_key_set_core_tb.sv]
// Self-checking testbench for the twelve-hour clock core with digit scan and key setting.
`timescale 1ns / 1ps

module clock_with_digit_scan_and_key_set_core_tb;
    import cwds_pkg::*;

    // The unused event kind. The core must still answer it with a result beat.
    localparam t_func      FUNC_UNUSED    = 2'd3;
    localparam int         ITEM_TARGET    = 450;
    localparam int         WATCHDOG_LIMIT = 200;
    localparam int         DRAIN_CYCLES   = 8;
    localparam int         MAX_SHOWN      = 60;

    // One result beat as the checker sees it.
    typedef struct packed {
        logic [5:0] enable_n;
        logic [3:0] value;
        logic       blank;
        logic [5:0] sec;
        logic [5:0] min;
        logic [3:0] hour;
        logic       active;
        logic [2:0] pos;
    } t_clock_view;

    // Tracks the clock, the display scan and the key entry, and keeps the
    // display views that the core still owes, oldest first.
    class clock_tracker;
        logic [5:0]  sec_cnt;
        logic [5:0]  min_cnt;
        logic [3:0]  hour_cnt;
        logic [2:0]  scan_idx;
        logic        entering;
        logic [2:0]  next_pos;
        logic [3:0]  ent_hour;
        logic [5:0]  ent_min;
        logic [5:0]  ent_sec;
        t_clock_view owed_views[$];
        int          errors;

        function new();
            sec_cnt  = SEC_RESET;
            min_cnt  = 6'd0;
            hour_cnt = HOUR_RESET;
            scan_idx = 3'd0;
            entering = 1'b0;
            next_pos = POS_HOUR_TENS;
            ent_hour = 4'd0;
            ent_min  = 6'd0;
            ent_sec  = 6'd0;
            errors   = 0;
        endfunction

        function int outstanding();
            return owed_views.size();
        endfunction

        function logic [38:0] state_word();
            return {sec_cnt, min_cnt, hour_cnt, scan_idx, entering, next_pos,
                    ent_hour, ent_min, ent_sec};
        endfunction

        function void apply_key(logic [7:0] k);
            logic [3:0] d;
            logic [3:0] top;
            if (!entering) begin
                if (k == KEY_ONE) begin
                    entering = 1'b1;
                    next_pos = POS_HOUR_TENS;
                end
                return;
            end
            if (k == KEY_EQUAL) begin
                entering = 1'b0;
                next_pos = POS_HOUR_TENS;
                return;
            end
            if (k < KEY_ZERO || k > KEY_NINE) return;
            d = k[3:0] - KEY_ZERO[3:0];
            // Hour units may go to 9 only after a zero tens digit.
            case (next_pos)
                POS_HOUR_TENS:               top = 4'd1;
                POS_HOUR_UNITS:              top = (ent_hour >= HOUR_TEN) ? 4'd2 : 4'd9;
                POS_MIN_TENS, POS_SEC_TENS:  top = 4'd5;
                POS_MIN_UNITS, POS_SEC_UNITS: top = 4'd9;
                default:                     return;
            endcase
            if (d > top) return;
            case (next_pos)
                POS_HOUR_TENS:  ent_hour = d * 4'd10;
                POS_HOUR_UNITS: ent_hour = ent_hour + d;
                POS_MIN_TENS:   ent_min  = {2'b00, d} * 6'd10;
                POS_MIN_UNITS:  ent_min  = ent_min + {2'b00, d};
                POS_SEC_TENS:   ent_sec  = {2'b00, d} * 6'd10;
                default: begin
                    // The last digit loads the whole entered time at once.
                    ent_sec  = ent_sec + {2'b00, d};
                    sec_cnt  = ent_sec;
                    min_cnt  = ent_min;
                    hour_cnt = ent_hour;
                    entering = 1'b0;
                    next_pos = POS_HOUR_TENS;
                    return;
                end
            endcase
            next_pos = next_pos - 3'd1;
        endfunction

        function t_clock_view current_view();
            t_clock_view v;
            logic [5:0]  field;
            logic [5:0]  digit;
            logic        over;
            case (scan_idx)
                3'd0, 3'd1: begin
                    field = sec_cnt;
                    over  = sec_cnt > MS_MAX;
                end
                3'd2, 3'd3: begin
                    field = min_cnt;
                    over  = min_cnt > MS_MAX;
                end
                default: begin
                    field = {2'b00, hour_cnt};
                    over  = hour_cnt > HOUR_MAX;
                end
            endcase
            // Even scan positions show units, odd ones show tens.
            digit      = scan_idx[0] ? field / 6'd10 : field % 6'd10;
            v.enable_n = ~(6'b000001 << scan_idx);
            v.value    = over ? 4'd0 : digit[3:0];
            v.blank    = over;
            v.sec      = sec_cnt;
            v.min      = min_cnt;
            v.hour     = hour_cnt;
            v.active   = entering;
            v.pos      = next_pos;
            return v;
        endfunction

        // Notes an accepted event beat; returns 1 when it moved the state.
        function bit take_event(t_func f, logic [7:0] k);
            logic [38:0] prior;
            prior = state_word();
            case (f)
                FUNC_SEC: begin
                    if (sec_cnt >= MS_MAX) begin
                        sec_cnt = 6'd0;
                        if (min_cnt >= MS_MAX) begin
                            min_cnt  = 6'd0;
                            hour_cnt = (hour_cnt >= HOUR_MAX) ? HOUR_FIRST : hour_cnt + 4'd1;
                        end else begin
                            min_cnt = min_cnt + 6'd1;
                        end
                    end else begin
                        sec_cnt = sec_cnt + 6'd1;
                    end
                end
                FUNC_SCAN: scan_idx = (scan_idx >= 3'(DIGIT_COUNT - 1)) ? 3'd0 : scan_idx + 3'd1;
                FUNC_KEY:  apply_key(k);
                default: ;
            endcase
            owed_views.push_back(current_view());
            return f == FUNC_SEC || f == FUNC_SCAN || prior != state_word();
        endfunction

        task report(string what, int got_v, int want_v);
            if (errors < MAX_SHOWN)
                $display("[%0t] mismatch %s: got %0d, expected %0d",
                         $time, what, got_v, want_v);
            errors++;
        endtask

        task match_display(t_clock_view got);
            t_clock_view want;
            if (owed_views.size() == 0) begin
                report("result beat with nothing owed, seconds", int'(got.sec), -1);
                return;
            end
            want = owed_views.pop_front();
            if (got.enable_n != want.enable_n)
                report("digit_enable_n", int'(got.enable_n), int'(want.enable_n));
            if (got.value != want.value)
                report("digit_value", int'(got.value), int'(want.value));
            if (got.blank != want.blank)
                report("digit_blank", int'(got.blank), int'(want.blank));
            if (got.sec != want.sec)
                report("seconds_now", int'(got.sec), int'(want.sec));
            if (got.min != want.min)
                report("minutes_now", int'(got.min), int'(want.min));
            if (got.hour != want.hour)
                report("hours_now", int'(got.hour), int'(want.hour));
            if (got.active != want.active)
                report("entry_active", int'(got.active), int'(want.active));
            if (got.pos != want.pos)
                report("entry_position", int'(got.pos), int'(want.pos));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    cwds_evt_if evt_bus ();
    cwds_res_if res_bus ();

    clock_with_digit_scan_and_key_set_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (evt_bus),
        .o_res   (res_bus)
    );

    clock_tracker board = new();

    // Count of beats that moved the clock, the scan or the entry state.
    int moves;
    // While set, both sides drive back to back with no idle cycles.
    bit steady;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(0, 5);
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Offers one event beat after a random idle gap and returns at the edge
    // that takes it. The valid line is only lowered when a gap follows, so it
    // never gets two updates in one step.
    task automatic send_event(input t_func f, input logic [7:0] k);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            evt_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        evt_bus.valid    <= 1'b1;
        evt_bus.func     <= f;
        evt_bus.key_code <= k;
        do @(posedge i_clk); while (!evt_bus.ready);
        if (board.take_event(f, k)) moves++;
    endtask

    task automatic send_key(input logic [7:0] k);
        send_event(FUNC_KEY, k);
    endtask

    task automatic send_keys(input string keys);
        int i;
        for (i = 0; i < keys.len(); i++) send_key(keys[i]);
    endtask

    // Holds the event side off until the core has delivered every owed beat.
    task automatic hold_until_drained();
        evt_bus.valid <= 1'b0;
        do @(posedge i_clk); while (board.outstanding() != 0);
    endtask

    // Keys in a full hh mm ss entry. Along the way a tick, a refused digit or
    // a stray key may slip in; quit_at below six leaves the entry with '='.
    task automatic set_time_by_keys(input int h, input int m, input int s, input int quit_at);
        int         dig[6];
        int         i;
        int         bad;
        logic [7:0] stray;
        dig[0] = h / 10;
        dig[1] = h % 10;
        dig[2] = m / 10;
        dig[3] = m % 10;
        dig[4] = s / 10;
        dig[5] = s % 10;
        if (board.entering) send_key(KEY_EQUAL);
        send_key(KEY_ONE);
        for (i = 0; i < 6; i++) begin
            if (i == quit_at) begin
                send_key(KEY_EQUAL);
                return;
            end
            case ($urandom_range(0, 11))
                0: send_event(FUNC_SEC, rand_byte());
                1: send_event(FUNC_SCAN, rand_byte());
                2: begin
                    // A digit above the range of this position must be refused.
                    if (i == 0)                      bad = $urandom_range(2, 9);
                    else if (i == 1 && dig[0] == 1)  bad = $urandom_range(3, 9);
                    else if (i == 2 || i == 4)       bad = $urandom_range(6, 9);
                    else                             bad = -1;
                    if (bad >= 0) send_key(KEY_ZERO + bad[7:0]);
                end
                3: begin
                    // Anything past the digits and '=' is ignored while entering.
                    stray = 8'($urandom_range(62, 255));
                    send_key(stray);
                end
                default: ;
            endcase
            send_key(KEY_ZERO + dig[i][7:0]);
        end
    endtask

    // Result side: random stalls, then one beat taken and checked.
    initial begin : result_sink
        int          gap;
        t_clock_view got;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                res_bus.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!res_bus.valid);
            got.enable_n = res_bus.digit_enable_n;
            got.value    = res_bus.digit_value;
            got.blank    = res_bus.digit_blank;
            got.sec      = res_bus.seconds_now;
            got.min      = res_bus.minutes_now;
            got.hour     = res_bus.hours_now;
            got.active   = res_bus.entry_active;
            got.pos      = res_bus.entry_position;
            board.match_display(got);
        end
    end

    // Ends the run when no beat moves on either channel for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (evt_bus.valid && evt_bus.ready) || (res_bus.valid && res_bus.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        int          pick;
        int          h;
        int          m;
        int          s;
        int          quit_at;
        t_clock_view left_view;
        i_rst_n          <= 1'b0;
        evt_bus.valid    <= 1'b0;
        evt_bus.func     <= FUNC_SEC;
        evt_bus.key_code <= 8'd0;
        res_bus.ready    <= 1'b0;
        moves  = 0;
        steady = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. The unused event kind still gets a result.
        send_event(FUNC_UNUSED, 8'hFF);
        // '=' and a letter with no entry open are ignored, then an entry is
        // opened and left, then 12:59:59 is keyed in past refused digits
        // for each hour digit and the minute tens, with a stray letter.
        send_keys("=A1=12132659A59");
        // One tick carries through minutes and wraps the hour from 12 to 1.
        send_event(FUNC_SEC, 8'h00);
        // Hour 00 is taken as is; the next hour carry makes it 1.
        send_keys("1005959");
        send_event(FUNC_SEC, 8'hFF);
        // Walk the scan over all six digits and back to the seconds units.
        repeat (DIGIT_COUNT) send_event(FUNC_SCAN, rand_byte());
        hold_until_drained();

        // Random part: mostly well-formed entries and tick bursts, some noise.
        while (moves < ITEM_TARGET) begin
            if ($urandom_range(0, 5) == 0) steady = !steady;
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                case ($urandom_range(0, 7))
                    0:       h = 0;
                    1:       h = 12;
                    default: begin
                        h = $urandom_range(0, 1) * 10;
                        h = h + ((h == 10) ? $urandom_range(0, 2) : $urandom_range(0, 9));
                    end
                endcase
                m = ($urandom_range(0, 2) == 0) ? 59 : $urandom_range(0, 59);
                s = ($urandom_range(0, 2) == 0) ? $urandom_range(50, 59) : $urandom_range(0, 59);
                quit_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 5) : 6;
                set_time_by_keys(h, m, s, quit_at);
                // Ticks right after a load push near-limit times over their carries.
                if ($urandom_range(0, 1) == 1)
                    repeat ($urandom_range(1, 12)) send_event(FUNC_SEC, rand_byte());
            end else if (pick < 65) begin
                repeat ($urandom_range(1, 25)) send_event(FUNC_SEC, rand_byte());
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 8)) send_event(FUNC_SCAN, rand_byte());
            end else if (pick < 95) begin
                repeat ($urandom_range(1, 4))
                    send_event(t_func'($urandom_range(0, 3)), rand_byte());
            end else begin
                hold_until_drained();
            end
        end

        hold_until_drained();
        // Give a stray extra beat time to show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        while (board.outstanding() != 0) begin
            left_view = board.owed_views.pop_front();
            board.report("result beat never delivered, seconds", -1, int'(left_view.sec));
        end
        if (board.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
